@@ rtl/core/lrtsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lrtsm_pkg: shared types and constants for the trim range splitter
// Transfer payloads, the internal command format and the sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lrtsm_pkg;

	// Blocks in one slice and the related widths
	localparam int unsigned BLOCKS_PER_SLICE = 4;
	localparam int unsigned OFFSET_W         = 2;
	localparam int unsigned SLICE_W          = 30;
	localparam int unsigned LBA_W            = 32;

	// Supported range length and the width that holds it
	localparam int unsigned MAX_RANGE_BLOCKS_DEF = 252;
	localparam int unsigned COUNT_W              = 8;

	// Depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Input transfer
	typedef struct packed {
		logic [LBA_W-1:0] start_block;
		logic [LBA_W-1:0] block_count;
		logic             final_range;
	} in_item_t;

	// Result transfer
	typedef struct packed {
		logic [SLICE_W-1:0]          slice_addr;
		logic [BLOCKS_PER_SLICE-1:0] block_mask;
		logic                        last_of_range;
		logic                        end_of_request;
		logic                        length_error;
	} out_item_t;

	// Classified range handed from front to back
	typedef struct packed {
		logic [SLICE_W-1:0]  slice_addr;
		logic [OFFSET_W-1:0] head_offset;
		logic [COUNT_W-1:0]  block_count;
		logic                final_range;
		logic                length_error;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/lrtsm_front.sv @@
// ----------------------------------------------------------------------------
// lrtsm_front: range classifier
// Checks each range for an empty or oversized count and turns it into a
// slice command for the queue; empty ranges are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module lrtsm_front #(
	parameter int unsigned MAX_RANGE_BLOCKS = lrtsm_pkg::MAX_RANGE_BLOCKS_DEF
) (
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire lrtsm_pkg::in_item_t in_data,
	output logic                     push,
	output lrtsm_pkg::cmd_t          push_cmd,
	input  wire logic                queue_full
);

	logic count_zero;
	logic count_over;

	// Classify the count
	assign count_zero = (in_data.block_count == '0);
	assign count_over = (in_data.block_count > lrtsm_pkg::LBA_W'(MAX_RANGE_BLOCKS));

	// Accept while the queue has room; drop empty ranges
	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full && !count_zero;

	// Build the command
	always_comb begin
		push_cmd.slice_addr   = in_data.start_block[lrtsm_pkg::LBA_W-1:lrtsm_pkg::OFFSET_W];
		push_cmd.head_offset  = in_data.start_block[lrtsm_pkg::OFFSET_W-1:0];
		push_cmd.block_count  = in_data.block_count[lrtsm_pkg::COUNT_W-1:0];
		push_cmd.final_range  = in_data.final_range;
		push_cmd.length_error = count_over;
	end

endmodule

`default_nettype wire

@@ rtl/core/lrtsm_queue.sv @@
// ----------------------------------------------------------------------------
// lrtsm_queue: command queue
// Small register queue that decouples the classifier from the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module lrtsm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lrtsm_pkg::cmd_t push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output lrtsm_pkg::cmd_t      head_cmd
);

	localparam int unsigned PTR_W = (lrtsm_pkg::QUEUE_DEPTH > 1) ?
		$clog2(lrtsm_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(lrtsm_pkg::QUEUE_DEPTH + 1);

	lrtsm_pkg::cmd_t  entry_q [lrtsm_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full      = (fill_q == CNT_W'(lrtsm_pkg::QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];

	// Store incoming commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lrtsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lrtsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lrtsm_back.sv @@
// ----------------------------------------------------------------------------
// lrtsm_back: slice splitter
// Walks one command slice by slice and emits a slice address and block mask
// per slice through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module lrtsm_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire lrtsm_pkg::cmd_t      cmd,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output lrtsm_pkg::out_item_t      out_data
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SPLIT = 2'b10
	} state_t;

	state_t                              state_q;
	logic [lrtsm_pkg::SLICE_W-1:0]       cursor_q;
	logic [lrtsm_pkg::OFFSET_W-1:0]      offset_q;
	logic [lrtsm_pkg::COUNT_W-1:0]       left_q;
	logic                                final_q;
	logic                                err_q;
	logic                                out_valid_q;
	lrtsm_pkg::out_item_t                out_q;

	logic                                slot_free;
	logic [lrtsm_pkg::OFFSET_W:0]        room;
	logic [lrtsm_pkg::OFFSET_W:0]        take;
	logic [lrtsm_pkg::COUNT_W-1:0]       left_next;
	logic [lrtsm_pkg::BLOCKS_PER_SLICE-1:0] mask;
	logic                                last;

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && cmd_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Work out the blocks of the current slice
	always_comb begin
		room = (lrtsm_pkg::OFFSET_W+1)'(lrtsm_pkg::BLOCKS_PER_SLICE) - {1'b0, offset_q};
		if (left_q < lrtsm_pkg::COUNT_W'(room)) begin
			take = left_q[lrtsm_pkg::OFFSET_W:0];
		end else begin
			take = room;
		end
		for (int k = 0; k < lrtsm_pkg::BLOCKS_PER_SLICE; k++) begin
			mask[k] = ((lrtsm_pkg::OFFSET_W+2)'(k) >= (lrtsm_pkg::OFFSET_W+2)'(offset_q)) &&
				((lrtsm_pkg::OFFSET_W+2)'(k) <
				 ((lrtsm_pkg::OFFSET_W+2)'(offset_q) + (lrtsm_pkg::OFFSET_W+2)'(take)));
		end
		left_next = left_q - lrtsm_pkg::COUNT_W'(take);
		last      = (left_next == '0);
	end

	// Load commands and step through slices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= (state_q == ST_SPLIT);
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (slot_free && (err_q || last)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the range state and the output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cursor_q <= cmd.slice_addr;
			offset_q <= cmd.head_offset;
			left_q   <= cmd.block_count;
			final_q  <= cmd.final_range;
			err_q    <= cmd.length_error;
		end else if ((state_q == ST_SPLIT) && slot_free) begin
			cursor_q <= cursor_q + 1'b1;
			offset_q <= '0;
			left_q   <= left_next;
		end
		if ((state_q == ST_SPLIT) && slot_free) begin
			out_q.slice_addr <= cursor_q;
			if (err_q) begin
				out_q.block_mask     <= '0;
				out_q.last_of_range  <= 1'b1;
				out_q.end_of_request <= final_q;
				out_q.length_error   <= 1'b1;
			end else begin
				out_q.block_mask     <= mask;
				out_q.last_of_range  <= last;
				out_q.end_of_request <= last && final_q;
				out_q.length_error   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lba_range_to_slice_trim_masks_top.sv @@
// A range passes the command queue and the splitter's range registers; results
// leave the output register at one slice per cycle unless stalled (up to 64
// per range). An oversized range gives one error result. Empty ranges are
// dropped by the classifier; a 2-entry command queue lets new ranges be taken
// while the splitter works. Reset clears all control state at once.
// ----------------------------------------------------------------------------
// lba_range_to_slice_trim_masks_top: trim range to slice masks
// Splits trim ranges into per-slice block masks via classifier, queue and
// splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module lba_range_to_slice_trim_masks_top #(
	parameter int unsigned MAX_RANGE_BLOCKS = lrtsm_pkg::MAX_RANGE_BLOCKS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire lrtsm_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output lrtsm_pkg::out_item_t      out_data
);

	logic            push;
	lrtsm_pkg::cmd_t push_cmd;
	logic            queue_full;
	logic            pop;
	logic            queue_not_empty;
	lrtsm_pkg::cmd_t head_cmd;

	// Classify incoming ranges
	lrtsm_front #(
		.MAX_RANGE_BLOCKS(MAX_RANGE_BLOCKS)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_cmd  (push_cmd),
		.queue_full(queue_full)
	);

	// Buffer commands
	lrtsm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.not_empty(queue_not_empty),
		.head_cmd (head_cmd)
	);

	// Split into slices
	lrtsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(queue_not_empty),
		.cmd      (head_cmd),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

@@ rtl/core/lrtsm_checker.sv @@
// ----------------------------------------------------------------------------
// lrtsm_checker: port checks for the trim range splitter
// Watches both channels for stall behaviour and the result for mask consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module lrtsm_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire lrtsm_pkg::in_item_t  in_data,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire lrtsm_pkg::out_item_t out_data
);

	// Hold an offered range until it transfers
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("range changed while waiting");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Error results carry no mask and close the range
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.length_error |->
			(out_data.block_mask == '0) && out_data.last_of_range)
		else $error("malformed length error result");

	// Valid slices always trim something
	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.length_error |-> (out_data.block_mask != '0))
		else $error("empty mask on a normal result");

	// End of request only on the last slice of a range
	a_eor_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_request |-> out_data.last_of_range)
		else $error("end of request without last of range");

endmodule

bind lba_range_to_slice_trim_masks_top lrtsm_checker u_lrtsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

`default_nettype wire

@@ verif/lba_range_to_slice_trim_masks_top_test.sv @@
// ----------------------------------------------------------------------------
// lba_range_to_slice_trim_masks_top_test: self-checking bench for the splitter
// Posts trim ranges through the input handshake and works out the slice
// commands each one must give. Every result transfer is checked in order
// against that list. Both sides stall at random, except for one steady stretch.
// ----------------------------------------------------------------------------
module lba_range_to_slice_trim_masks_top_test;

	localparam int unsigned RANGE_LIMIT    = lrtsm_pkg::MAX_RANGE_BLOCKS_DEF;
	localparam int unsigned STALL_PCT      = 37;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	lrtsm_pkg::in_item_t  in_data;
	logic                 out_valid;
	logic                 out_ready;
	lrtsm_pkg::out_item_t out_data;

	// Slice commands still owed by the block, oldest first
	lrtsm_pkg::out_item_t slices_due[$];
	int unsigned          mismatches;
	int unsigned          quiet_cycles;
	bit                   stalls_on;

	lba_range_to_slice_trim_masks_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Work out the slice commands one accepted range must give
	function automatic void split_range(input lrtsm_pkg::in_item_t item);
		bit [lrtsm_pkg::SLICE_W-1:0]  cursor;
		bit [lrtsm_pkg::OFFSET_W-1:0] offset;
		bit [8:0]                     left;
		bit [2:0]                     room;
		bit [2:0]                     take;
		bit [4:0]                     span;
		lrtsm_pkg::out_item_t         cmd;
		if (item.block_count == '0) begin
			return;
		end
		cursor = item.start_block[lrtsm_pkg::LBA_W-1:lrtsm_pkg::OFFSET_W];
		if (item.block_count > RANGE_LIMIT) begin
			cmd.slice_addr     = cursor;
			cmd.block_mask     = '0;
			cmd.last_of_range  = 1'b1;
			cmd.end_of_request = item.final_range;
			cmd.length_error   = 1'b1;
			slices_due.push_back(cmd);
			return;
		end
		offset = item.start_block[lrtsm_pkg::OFFSET_W-1:0];
		left   = item.block_count[8:0];
		while (left != '0) begin
			room = 3'd4 - {1'b0, offset};
			take = (left < 9'(room)) ? left[2:0] : room;
			span = (5'd1 << take) - 5'd1;
			left = left - 9'(take);
			cmd.slice_addr     = cursor;
			cmd.block_mask     = 4'(span << offset);
			cmd.last_of_range  = (left == '0);
			cmd.end_of_request = (left == '0) && item.final_range;
			cmd.length_error   = 1'b0;
			slices_due.push_back(cmd);
			cursor = cursor + 1'b1;
			offset = '0;
		end
	endfunction

	// Offer one range, hold it until the transfer, then record what it owes
	task automatic post_range(input logic [lrtsm_pkg::LBA_W-1:0] start,
			input logic [lrtsm_pkg::LBA_W-1:0] count, input logic fin);
		lrtsm_pkg::in_item_t item;
		item.start_block = start;
		item.block_count = count;
		item.final_range = fin;
		if (stalls_on) begin
			while ($urandom_range(0, 99) < STALL_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		split_range(item);
	endtask

	// Draw a range: mostly short valid ones, some long, empty, oversized or near the top
	task automatic post_random_range(input logic fin);
		logic [lrtsm_pkg::LBA_W-1:0] start;
		logic [lrtsm_pkg::LBA_W-1:0] count;
		int unsigned                 pick;
		start = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			start = 32'hFFFF_FFFF - $urandom_range(0, 40);
		end
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			count = '0;
		end else if (pick < 15) begin
			count = RANGE_LIMIT;
		end else if (pick < 22) begin
			count = $urandom_range(RANGE_LIMIT + 1, RANGE_LIMIT + 8);
		end else if (pick < 30) begin
			count = $urandom_range(RANGE_LIMIT + 1, 32'hFFFF_FFFF);
		end else if (pick < 85) begin
			count = $urandom_range(1, 16);
		end else begin
			count = $urandom_range(17, RANGE_LIMIT - 1);
		end
		post_range(start, count, fin);
	endtask

	// Drop valid and hold off until every owed command has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (slices_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Field extremes, empty and oversized ranges, unaligned heads and address wrap
	task automatic test_directed_corners();
		post_range(32'h0000_0000, 32'h0000_0000, 1'b0);
		post_range(32'h0000_0013, 32'h0000_0000, 1'b1);
		post_range(32'h0000_0000, 32'h0000_0001, 1'b0);
		post_range(32'h0000_0003, 32'h0000_0001, 1'b1);
		post_range(32'h0000_0000, 32'h0000_0004, 1'b1);
		post_range(32'h0000_0001, 32'h0000_0004, 1'b0);
		post_range(32'h0000_0001, 32'h0000_0002, 1'b0);
		post_range(32'h0000_0001, 32'h0000_0003, 1'b1);
		post_range(32'h0000_0003, 32'h0000_0005, 1'b1);
		post_range(32'h0000_0000, RANGE_LIMIT, 1'b1);
		post_range(32'h0000_0002, RANGE_LIMIT, 1'b0);
		post_range(32'h1234_5677, RANGE_LIMIT + 1, 1'b1);
		post_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		post_range(32'h5555_5555, 32'h8000_0000, 1'b1);
		post_range(32'hFFFF_FFFD, 32'h0000_0008, 1'b1);
		post_range(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		post_range(32'hAAAA_AAAA, 32'h0000_0007, 1'b1);
	endtask

	// Whole requests: a few ranges, only the last flagged final
	task automatic test_request_sequences(input int unsigned n_requests);
		int unsigned n_ranges;
		repeat (n_requests) begin
			n_ranges = $urandom_range(1, 4);
			for (int unsigned k = 1; k <= n_ranges; k++) begin
				post_random_range(k == n_ranges);
			end
		end
	endtask

	// Back-to-back offers with no input gaps and the result side always ready
	task automatic test_steady_stream(input int unsigned n_items);
		stalls_on = 1'b0;
		repeat (n_items) begin
			post_random_range(1'($urandom_range(0, 1)));
		end
		stalls_on = 1'b1;
	endtask

	// Let the block run dry between bursts
	task automatic test_drain_pause(input int unsigned n_items);
		repeat (n_items) begin
			post_random_range(1'($urandom_range(0, 1)));
		end
		wait_drained();
		repeat (n_items) begin
			post_random_range(1'($urandom_range(0, 1)));
		end
	endtask

	// Flag one field that differs from the owed command
	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Check each result transfer against the oldest owed command, then pick ready
	always @(posedge clk) begin : check_slices
		lrtsm_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			if (slices_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, out_data);
				mismatches++;
			end else begin
				want = slices_due.pop_front();
				report_field("slice_addr", 32'(want.slice_addr), 32'(out_data.slice_addr));
				report_field("block_mask", 32'(want.block_mask), 32'(out_data.block_mask));
				report_field("last_of_range", 32'(want.last_of_range),
					32'(out_data.last_of_range));
				report_field("end_of_request", 32'(want.end_of_request),
					32'(out_data.end_of_request));
				report_field("length_error", 32'(want.length_error),
					32'(out_data.length_error));
			end
		end
		out_ready <= !stalls_on || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// End the run if nothing transfers for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		stalls_on    = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_request_sequences(10);
		test_steady_stream(30);
		test_drain_pause(6);
		test_request_sequences(10);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ lba_range_to_slice_trim_masks_top.f @@
rtl/core/lrtsm_pkg.sv
rtl/core/lrtsm_front.sv
rtl/core/lrtsm_queue.sv
rtl/core/lrtsm_back.sv
rtl/core/lba_range_to_slice_trim_masks_top.sv
rtl/core/lrtsm_checker.sv
verif/lba_range_to_slice_trim_masks_top_test.sv
